/* sv/three_stop_gradient_color_map_top_macros.svh */
// assertion helpers shared by the color ramp modules
`ifndef THREE_STOP_GRADIENT_COLOR_MAP_TOP_MACROS_SVH
`define THREE_STOP_GRADIENT_COLOR_MAP_TOP_MACROS_SVH

// same-cycle implication
`define TSCM_ASSERT_IMPLY(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tscm assertion failed");

// next-cycle implication
`define TSCM_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tscm assertion failed");

`endif

/* sv/tscm_pkg.sv */
package tscm_pkg;

    localparam int CHANNELS  = 3;
    localparam int DIV_CELLS = 8;

    localparam logic [2:0] REG_STOP1   = 3'd0;
    localparam logic [2:0] REG_STOP2   = 3'd1;
    localparam logic [2:0] REG_STOP3   = 3'd2;
    localparam logic [2:0] REG_COLOR_A = 3'd3;
    localparam logic [2:0] REG_COLOR_B = 3'd4;
    localparam logic [2:0] REG_COLOR_C = 3'd5;

    localparam logic [7:0]  STOP1_RESET   = 8'd85;
    localparam logic [7:0]  STOP2_RESET   = 8'd170;
    localparam logic [7:0]  STOP3_RESET   = 8'd255;
    localparam logic [23:0] COLOR_A_RESET = 24'h000000;
    localparam logic [23:0] COLOR_B_RESET = 24'h808080;
    localparam logic [23:0] COLOR_C_RESET = 24'hFFFFFF;

    typedef struct packed {
        logic [7:0]  den;
        logic [7:0]  num;
        logic [23:0] lo;
        logic [23:0] hi;
    } tscm_sel_t;

    // rem is the partial remainder, low shifts numerator bits out and quotient bits in
    typedef struct packed {
        logic [7:0]                den;
        logic [CHANNELS-1:0][7:0]  rem;
        logic [CHANNELS-1:0][7:0]  low;
    } tscm_div_t;

endpackage

/* sv/three_stop_gradient_color_map_top.sv */
// stages from input transfer to output transfer: select, multiply, 8 divide cells
// throughput: one item per cycle while out_stall is low, each cell resolves one quotient bit for all three channels
// a stage advances whenever the stage after it is empty or moving, so bubbles collapse
// reset: pipeline empties, stops return to 85/170/255, colors to black/grey/white
module three_stop_gradient_color_map_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  grey_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue
);

    logic [7:0]  stop1_reg;
    logic [7:0]  stop2_reg;
    logic [7:0]  stop3_reg;
    logic [23:0] color_a_reg;
    logic [23:0] color_b_reg;
    logic [23:0] color_c_reg;

    logic                 sel_ready;
    logic                 sel_valid;
    tscm_pkg::tscm_sel_t  sel_data;
    logic                 mul_ready;

    logic                 chain_valid [tscm_pkg::DIV_CELLS+1];
    logic                 chain_ready [tscm_pkg::DIV_CELLS+1];
    tscm_pkg::tscm_div_t  chain_data  [tscm_pkg::DIV_CELLS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop1_reg   <= tscm_pkg::STOP1_RESET;
            stop2_reg   <= tscm_pkg::STOP2_RESET;
            stop3_reg   <= tscm_pkg::STOP3_RESET;
            color_a_reg <= tscm_pkg::COLOR_A_RESET;
            color_b_reg <= tscm_pkg::COLOR_B_RESET;
            color_c_reg <= tscm_pkg::COLOR_C_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tscm_pkg::REG_STOP1:   stop1_reg   <= cfg_data[7:0];
                tscm_pkg::REG_STOP2:   stop2_reg   <= cfg_data[7:0];
                tscm_pkg::REG_STOP3:   stop3_reg   <= cfg_data[7:0];
                tscm_pkg::REG_COLOR_A: color_a_reg <= cfg_data;
                tscm_pkg::REG_COLOR_B: color_b_reg <= cfg_data;
                tscm_pkg::REG_COLOR_C: color_c_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    tscm_select u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .grey     (grey_level),
        .stop1    (stop1_reg),
        .stop2    (stop2_reg),
        .stop3    (stop3_reg),
        .color_a  (color_a_reg),
        .color_b  (color_b_reg),
        .color_c  (color_c_reg),
        .up_ready (sel_ready),
        .dn_valid (sel_valid),
        .dn_data  (sel_data),
        .dn_ready (mul_ready)
    );

    tscm_blend_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sel_valid),
        .up_data  (sel_data),
        .up_ready (mul_ready),
        .dn_valid (chain_valid[0]),
        .dn_data  (chain_data[0]),
        .dn_ready (chain_ready[0])
    );

    for (genvar i = 0; i < tscm_pkg::DIV_CELLS; i++)
    begin : g_cell
        tscm_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_data  (chain_data[i]),
            .up_ready (chain_ready[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_data  (chain_data[i+1]),
            .dn_ready (chain_ready[i+1])
        );
    end

    assign chain_ready[tscm_pkg::DIV_CELLS] = !out_stall;

    assign in_stall  = !sel_ready;
    assign out_valid = chain_valid[tscm_pkg::DIV_CELLS];
    assign out_red   = chain_data[tscm_pkg::DIV_CELLS].low[2];
    assign out_green = chain_data[tscm_pkg::DIV_CELLS].low[1];
    assign out_blue  = chain_data[tscm_pkg::DIV_CELLS].low[0];

endmodule

/* sv/tscm_select.sv */
`include "three_stop_gradient_color_map_top_macros.svh"

module tscm_select (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  logic [7:0]           grey,
    input  logic [7:0]           stop1,
    input  logic [7:0]           stop2,
    input  logic [7:0]           stop3,
    input  logic [23:0]          color_a,
    input  logic [23:0]          color_b,
    input  logic [23:0]          color_c,
    output logic                 up_ready,
    output logic                 dn_valid,
    output tscm_pkg::tscm_sel_t  dn_data,
    input  logic                 dn_ready
);

    logic                valid_reg;
    logic                valid_next;
    tscm_pkg::tscm_sel_t data_reg;
    tscm_pkg::tscm_sel_t data_next;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // constant segments use the fraction 0/1 so the blend returns the lower color
    always_comb
    begin
        data_next = data_reg;
        if (grey < stop1)
        begin
            data_next.lo  = color_a;
            data_next.hi  = color_a;
            data_next.num = 8'd0;
            data_next.den = 8'd1;
        end
        else if (grey < stop2)
        begin
            data_next.lo  = color_a;
            data_next.hi  = color_b;
            data_next.num = grey - stop1;
            data_next.den = stop2 - stop1;
        end
        else if (grey < stop3)
        begin
            data_next.lo  = color_b;
            data_next.hi  = color_c;
            data_next.num = grey - stop2;
            data_next.den = stop3 - stop2;
        end
        else
        begin
            data_next.lo  = color_c;
            data_next.hi  = color_c;
            data_next.num = 8'd0;
            data_next.den = 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    `TSCM_ASSERT_IMPLY(a_sel_frac, clk, rst_n, valid_reg, data_reg.num < data_reg.den)
    `TSCM_ASSERT_NEXT(a_sel_hold, clk, rst_n, valid_reg && !dn_ready, valid_reg)

endmodule

/* sv/tscm_blend_mul.sv */
module tscm_blend_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  tscm_pkg::tscm_sel_t  up_data,
    output logic                 up_ready,
    output logic                 dn_valid,
    output tscm_pkg::tscm_div_t  dn_data,
    input  logic                 dn_ready
);

    logic                                       valid_reg;
    logic                                       valid_next;
    tscm_pkg::tscm_div_t                        data_reg;
    tscm_pkg::tscm_div_t                        data_next;
    logic [tscm_pkg::CHANNELS-1:0][15:0]        numer;
    logic [7:0]                                 weight_lo;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;
    assign weight_lo  = up_data.den - up_data.num;

    // numerator never exceeds 255 * den, so the top byte starts below den
    always_comb
    begin
        data_next     = data_reg;
        data_next.den = up_data.den;
        for (int c = 0; c < tscm_pkg::CHANNELS; c++)
        begin
            numer[c] = 16'(up_data.lo[c*8 +: 8]) * 16'(weight_lo)
                     + 16'(up_data.hi[c*8 +: 8]) * 16'(up_data.num);
            data_next.rem[c] = numer[c][15:8];
            data_next.low[c] = numer[c][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* sv/tscm_div_cell.sv */
`include "three_stop_gradient_color_map_top_macros.svh"

module tscm_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  tscm_pkg::tscm_div_t  up_data,
    output logic                 up_ready,
    output logic                 dn_valid,
    output tscm_pkg::tscm_div_t  dn_data,
    input  logic                 dn_ready
);

    logic                                 valid_reg;
    logic                                 valid_next;
    tscm_pkg::tscm_div_t                  data_reg;
    tscm_pkg::tscm_div_t                  data_next;
    logic [tscm_pkg::CHANNELS-1:0][8:0]   trial;
    logic [tscm_pkg::CHANNELS-1:0][8:0]   diff;
    logic [tscm_pkg::CHANNELS-1:0]        qbit;
    logic [tscm_pkg::CHANNELS-1:0]        rem_lt;

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // one restoring step: bring down a numerator bit, subtract if it fits
    always_comb
    begin
        data_next     = data_reg;
        data_next.den = up_data.den;
        for (int c = 0; c < tscm_pkg::CHANNELS; c++)
        begin
            trial[c] = {up_data.rem[c], up_data.low[c][7]};
            diff[c]  = trial[c] - {1'b0, up_data.den};
            qbit[c]  = (trial[c] >= {1'b0, up_data.den});
            data_next.rem[c] = qbit[c] ? diff[c][7:0] : trial[c][7:0];
            data_next.low[c] = {up_data.low[c][6:0], qbit[c]};
        end
    end

    always_comb
    begin
        for (int c = 0; c < tscm_pkg::CHANNELS; c++)
        begin
            rem_lt[c] = (data_reg.rem[c] < data_reg.den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    `TSCM_ASSERT_IMPLY(a_cell_den_nz, clk, rst_n, valid_reg, data_reg.den != 8'd0)
    `TSCM_ASSERT_IMPLY(a_cell_rem_lt, clk, rst_n, valid_reg, &rem_lt)

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] REG_SPARE6 = 3'd6;
    localparam logic [2:0] REG_SPARE7 = 3'd7;
    localparam int DRAIN_CYCLES  = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } ramp_rgb_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  grey_level = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;

    // register image kept in step with the block
    logic [7:0]  stop_lvl [0:2] = '{tscm_pkg::STOP1_RESET, tscm_pkg::STOP2_RESET,
                                    tscm_pkg::STOP3_RESET};
    logic [23:0] stop_rgb [0:2] = '{tscm_pkg::COLOR_A_RESET, tscm_pkg::COLOR_B_RESET,
                                    tscm_pkg::COLOR_C_RESET};

    logic [7:0]  grey_q [$];
    ramp_rgb_t   color_q [$];

    int          levels_in = 0;
    int          colors_out = 0;
    int          mismatch_count = 0;
    int          settings_count = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          mode_left = 0;
    int          quiet_cycles = 0;
    stall_mode_t stall_mode = STALL_NONE;

    three_stop_gradient_color_map_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .grey_level (grey_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] blend_chan(input logic [7:0] ca, input logic [7:0] cb,
                                              input logic [7:0] num, input logic [7:0] den);
        int unsigned acc;
        if (den == 8'd0)
            return ca;
        acc = (int'(ca) * (int'(den) - int'(num)) + int'(cb) * int'(num)) / int'(den);
        return acc[7:0];
    endfunction

    function automatic ramp_rgb_t blend_rgb(input logic [23:0] lo, input logic [23:0] hi,
                                            input logic [7:0] num, input logic [7:0] den);
        ramp_rgb_t c;
        c.red   = blend_chan(lo[23:16], hi[23:16], num, den);
        c.green = blend_chan(lo[15:8], hi[15:8], num, den);
        c.blue  = blend_chan(lo[7:0], hi[7:0], num, den);
        return c;
    endfunction

    // color that the ramp gives for one grey level under the current registers
    function automatic ramp_rgb_t ramp_color(input logic [7:0] v);
        if (v < stop_lvl[0])
            return blend_rgb(stop_rgb[0], stop_rgb[0], 8'd0, 8'd0);
        else if (v < stop_lvl[1])
            return blend_rgb(stop_rgb[0], stop_rgb[1], v - stop_lvl[0], stop_lvl[1] - stop_lvl[0]);
        else if (v < stop_lvl[2])
            return blend_rgb(stop_rgb[1], stop_rgb[2], v - stop_lvl[1], stop_lvl[2] - stop_lvl[1]);
        else
            return blend_rgb(stop_rgb[2], stop_rgb[2], 8'd0, 8'd0);
    endfunction

    // half uniform, the rest near the stops or at the ends of the range
    function automatic logic [7:0] pick_grey();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4 || sel == 9)
            return 8'($urandom_range(255));
        else if (sel < 7)
            return stop_lvl[$urandom_range(2)] + 8'($urandom_range(4)) - 8'd2;
        else if (sel == 7)
            return 8'd0;
        else
            return 8'd255;
    endfunction

    task automatic check_chan(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tscm_pkg::REG_STOP1:   stop_lvl[0] = data[7:0];
            tscm_pkg::REG_STOP2:   stop_lvl[1] = data[7:0];
            tscm_pkg::REG_STOP3:   stop_lvl[2] = data[7:0];
            tscm_pkg::REG_COLOR_A: stop_rgb[0] = data;
            tscm_pkg::REG_COLOR_B: stop_rgb[1] = data;
            tscm_pkg::REG_COLOR_C: stop_rgb[2] = data;
            default: ;
        endcase
    endtask

    // upper data bits are junk, the block keeps only the low byte of a stop
    task automatic set_stops(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] s3);
        write_reg(tscm_pkg::REG_STOP1, {16'($urandom_range(16'hFFFF)), s1});
        write_reg(tscm_pkg::REG_STOP2, {16'($urandom_range(16'hFFFF)), s2});
        write_reg(tscm_pkg::REG_STOP3, {16'($urandom_range(16'hFFFF)), s3});
    endtask

    task automatic set_colors(input logic [23:0] a, input logic [23:0] b, input logic [23:0] c);
        write_reg(tscm_pkg::REG_COLOR_A, a);
        write_reg(tscm_pkg::REG_COLOR_B, b);
        write_reg(tscm_pkg::REG_COLOR_C, c);
    endtask

    task automatic wait_drain();
        do
            @(posedge clk);
        while (grey_q.size() != 0 || in_valid || color_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_levels(input int count);
        settings_count++;
        repeat (count) grey_q.push_back(pick_grey());
        wait_drain();
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                color_q.push_back(ramp_color(grey_level));
                levels_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (grey_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    grey_level <= grey_q.pop_front();
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern changes at random intervals, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(3) == 0);
                STALL_HEAVY:    out_stall <= ($urandom_range(3) != 0);
                STALL_PERIODIC: out_stall <= (mode_left % 3 == 0);
                default:        out_stall <= 1'b0;
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        ramp_rgb_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            colors_out++;
            if (color_q.size() == 0)
            begin
                $display("%0t: color transfer with nothing expected, actual %02h %02h %02h",
                         $time, out_red, out_green, out_blue);
                mismatch_count++;
            end
            else
            begin
                want = color_q.pop_front();
                check_chan("out_red", want.red, out_red);
                check_chan("out_green", want.green, out_green);
                check_chan("out_blue", want.blue, out_blue);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d colors still expected",
                         $time, quiet_cycles, color_q.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] s [0:2];
        logic [7:0] tmp;
        logic [7:0] edge_levels [0:12] = '{8'd0, 8'd1, 8'd84, 8'd85, 8'd86, 8'd127, 8'd128,
                                           8'd169, 8'd170, 8'd171, 8'd200, 8'd254, 8'd255};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset ramp: black to grey to white
        foreach (edge_levels[i])
            grey_q.push_back(edge_levels[i]);
        run_levels(100);

        // writes to unused indexes, then every stop and color is written anew
        write_reg(REG_SPARE6, 24'hFFFFFF);
        write_reg(REG_SPARE7, 24'h5A5A5A);
        set_stops(8'd40, 8'd200, 8'd230);
        set_colors(24'hFF0000, 24'h00FF00, 24'h0000FF);
        run_levels(120);

        // all stops at zero: everything is color c
        set_stops(8'd0, 8'd0, 8'd0);
        set_colors(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
                   24'($urandom_range(24'hFFFFFF)));
        run_levels(60);

        // all stops at the top: color a except at 255
        set_stops(8'd255, 8'd255, 8'd255);
        run_levels(60);

        // full-swing blends, with the output held off while input keeps coming
        set_stops(8'd0, 8'd128, 8'd255);
        set_colors(24'h000000, 24'hFFFFFF, 24'h000000);
        @(posedge clk);
        hold_req++;
        run_levels(150);

        // descending stops leave both blend segments empty
        set_stops(8'd200, 8'd100, 8'd50);
        run_levels(60);

        // first segment empty, second one wide
        set_stops(8'd10, 8'd5, 8'd250);
        set_colors(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
                   24'($urandom_range(24'hFFFFFF)));
        run_levels(120);

        // one-level segments
        set_stops(8'd0, 8'd1, 8'd2);
        set_colors(24'hFFFFFF, 24'h000000, 24'hFFFFFF);
        run_levels(60);

        // widest possible segment
        set_stops(8'd0, 8'd255, 8'd255);
        set_colors(24'hFFFFFF, 24'h000000, 24'($urandom_range(24'hFFFFFF)));
        run_levels(100);

        repeat (8)
        begin
            foreach (s[i])
                s[i] = 8'($urandom_range(255));
            if ($urandom_range(3) != 0)
            begin
                if (s[0] > s[1]) begin tmp = s[0]; s[0] = s[1]; s[1] = tmp; end
                if (s[1] > s[2]) begin tmp = s[1]; s[1] = s[2]; s[2] = tmp; end
                if (s[0] > s[1]) begin tmp = s[0]; s[0] = s[1]; s[1] = tmp; end
            end
            set_stops(s[0], s[1], s[2]);
            set_colors(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
                       24'($urandom_range(24'hFFFFFF)));
            run_levels(100);
        end

        $display("mapped %0d grey levels under %0d register settings, %0d colors checked",
                 levels_in, settings_count, colors_out);
        $display("stops ascending, equal, descending and at both ends; long output hold-off");
        if (mismatch_count == 0 && color_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/tscm_pkg.sv
sv/tscm_select.sv
sv/tscm_blend_mul.sv
sv/tscm_div_cell.sv
sv/three_stop_gradient_color_map_top.sv
sim/tb_top.sv
